// ===== rtl/tx_byte_stream_parser_assert.svh =====
// Assertion macros for the transaction byte stream parser.
`ifndef TX_BYTE_STREAM_PARSER_ASSERT_SVH
`define TX_BYTE_STREAM_PARSER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TBP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TBP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Field kinds, error codes and shared types of the transaction byte parser.
// ----------------------------------------------------------------------------
`default_nettype none
package tbp_pkg;
  localparam int unsigned COUNT_WIDTH_DEF  = 16;
  localparam int unsigned LENGTH_WIDTH_DEF = 20;

  typedef enum logic [4:0] {
    K_VERSION = 5'd0, K_MARKER = 5'd1, K_FLAG = 5'd2, K_INCOUNT = 5'd3,
    K_OUTPOINT = 5'd4, K_SIGLEN = 5'd5, K_SIG = 5'd6, K_SEQ = 5'd7,
    K_OUTCOUNT = 5'd8, K_VALUE = 5'd9, K_PKLEN = 5'd10, K_PK = 5'd11,
    K_WITCOUNT = 5'd12, K_WITLEN = 5'd13, K_WITDATA = 5'd14,
    K_LOCKTIME = 5'd15
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_COUNT = 2'd1, ERR_LENGTH = 2'd2
  } err_t;

  localparam logic [1:0] REG_MAX_COUNT  = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] REG_SEGWIT     = 2'd2;

  typedef struct packed {
    logic [7:0]  byte_value;
    kind_t       kind;
    logic        first;
    logic        last;
    logic [15:0] index;
    logic        tx_last;
    err_t        err;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/tbp_core.sv =====
// ----------------------------------------------------------------------------
// tbp_core
// Parse state and single-pass classification of one byte into up to two
// results. The state register is updated on every accepted transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module tbp_core #(
  parameter int unsigned COUNT_WIDTH  = tbp_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = tbp_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          data_byte,
  input  wire logic [15:0]         max_item_count,
  input  wire logic [19:0]         max_script_length,
  input  wire logic                segwit_enable,
  output tbp_pkg::result_t         res0,
  output tbp_pkg::result_t         res1,
  output logic [1:0]               res_count
);
  // Wide enough to compare any CompactSize against the limits: any set bit
  // above bit 31 means "over" regardless of the limit.
  tbp_pkg::kind_t    phase, phase_next;
  logic [5:0]        fbc, fbc_next;
  logic [31:0]       vlo, vlo_next;
  logic              vhi, vhi_next;
  logic [3:0]        vleft, vleft_next;
  logic [LENGTH_WIDTH-1:0] rem, rem_next;
  logic [COUNT_WIDTH-1:0]  in_tot, in_tot_next, elem, elem_next;
  logic [COUNT_WIDTH-1:0]  out_tot, out_tot_next, wit_left, wit_left_next;
  logic              has_wit, has_wit_next, held, held_next;

  localparam logic [COUNT_WIDTH-1:0]  CCAP = '1;
  localparam logic [LENGTH_WIDTH-1:0] LCAP = '1;
  logic [32:0] climit, llimit;

  always_comb begin
    if ({16'd0, max_item_count} < {{(32-COUNT_WIDTH){1'b0}}, CCAP})
      climit = {17'd0, max_item_count};
    else climit = {1'b0, {(32-COUNT_WIDTH){1'b0}}, CCAP};
    if ({12'd0, max_script_length} < {{(32-LENGTH_WIDTH){1'b0}}, LCAP})
      llimit = {13'd0, max_script_length};
    else llimit = {1'b0, {(32-LENGTH_WIDTH){1'b0}}, LCAP};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tbp_pkg::K_VERSION; fbc <= '0; vlo <= '0; vhi <= 1'b0;
      vleft <= '0; rem <= '0; in_tot <= '0; elem <= '0; out_tot <= '0;
      wit_left <= '0; has_wit <= 1'b0; held <= 1'b0;
    end else if (step) begin
      phase <= phase_next; fbc <= fbc_next; vlo <= vlo_next; vhi <= vhi_next;
      vleft <= vleft_next; rem <= rem_next; in_tot <= in_tot_next;
      elem <= elem_next; out_tot <= out_tot_next; wit_left <= wit_left_next;
      has_wit <= has_wit_next; held <= held_next;
    end
  end

  always_comb begin
    tbp_pkg::result_t r;
    tbp_pkg::kind_t   k;
    logic [5:0]       size;
    logic             done, is_count, vz, over;
    logic [COUNT_WIDTH-1:0] e1, wl1;
    logic [31:0]      shifted;
    phase_next = phase; fbc_next = fbc; vlo_next = vlo; vhi_next = vhi;
    vleft_next = vleft; rem_next = rem; in_tot_next = in_tot;
    elem_next = elem; out_tot_next = out_tot; wit_left_next = wit_left;
    has_wit_next = has_wit; held_next = 1'b0;
    res0 = '0; res1 = '0; res_count = 2'd1;
    r = '0; done = 1'b0; size = '0; e1 = '0; wl1 = '0; over = 1'b0;
    is_count = 1'b0; vz = 1'b0; shifted = '0;
    k = phase;

    if (held) begin
      if (data_byte == 8'h01) begin
        res0.kind = tbp_pkg::K_MARKER; res0.first = 1'b1; res0.last = 1'b1;
        res1.byte_value = data_byte; res1.kind = tbp_pkg::K_FLAG;
        res1.first = 1'b1; res1.last = 1'b1;
        has_wit_next = 1'b1; res_count = 2'd2;
      end else begin
        res0.kind = tbp_pkg::K_INCOUNT; res0.first = 1'b1; res0.last = 1'b1;
        in_tot_next = '0; elem_next = '0; k = tbp_pkg::K_OUTCOUNT;
        res_count = 2'd2;
      end
    end else if (phase == tbp_pkg::K_INCOUNT && vleft == '0 && !has_wit &&
                 segwit_enable && data_byte == 8'h00) begin
      held_next = 1'b1; res_count = 2'd0;
    end

    if (!(held && data_byte == 8'h01) && res_count != 2'd0) begin
      // Stray phase codes restart at a version field.
      if (k == tbp_pkg::K_MARKER || k == tbp_pkg::K_FLAG) begin
        k = tbp_pkg::K_VERSION; fbc_next = '0; vleft_next = '0;
      end
      r.byte_value = data_byte; r.kind = k;
      if ((k >= tbp_pkg::K_OUTPOINT && k <= tbp_pkg::K_SEQ) ||
          (k >= tbp_pkg::K_VALUE && k <= tbp_pkg::K_WITDATA))
        r.index = 16'(elem_next);
      case (k)
        tbp_pkg::K_OUTPOINT: size = 6'd36;
        tbp_pkg::K_VALUE:    size = 6'd8;
        tbp_pkg::K_VERSION, tbp_pkg::K_SEQ, tbp_pkg::K_LOCKTIME: size = 6'd4;
        default:             size = 6'd0;
      endcase
      e1 = elem_next + 1'b1;
      if (size != '0) begin
        if (k == tbp_pkg::K_VERSION && fbc_next == '0) begin
          has_wit_next = 1'b0; in_tot_next = '0; out_tot_next = '0;
          elem_next = '0; wit_left_next = '0; rem_next = '0;
        end
        r.first = (fbc_next == '0);
        fbc_next = fbc_next + 6'd1;
        if (fbc_next >= size) begin
          r.last = 1'b1; fbc_next = '0;
          case (k)
            tbp_pkg::K_VERSION:  phase_next = tbp_pkg::K_INCOUNT;
            tbp_pkg::K_OUTPOINT: phase_next = tbp_pkg::K_SIGLEN;
            tbp_pkg::K_VALUE:    phase_next = tbp_pkg::K_PKLEN;
            tbp_pkg::K_SEQ: begin
              if (e1 >= in_tot_next) begin
                elem_next = '0; phase_next = tbp_pkg::K_OUTCOUNT;
              end else begin
                elem_next = e1; phase_next = tbp_pkg::K_OUTPOINT;
              end
            end
            default: begin
              r.tx_last = 1'b1; phase_next = tbp_pkg::K_VERSION;
            end
          endcase
        end else phase_next = k;
      end else if (k == tbp_pkg::K_SIG || k == tbp_pkg::K_PK ||
                   k == tbp_pkg::K_WITDATA) begin
        r.first = (fbc_next == '0);
        fbc_next = 6'd1;
        if (rem != '0) rem_next = rem - 1'b1;
        phase_next = k;
        if (rem_next == '0) begin
          r.last = 1'b1; fbc_next = '0;
          case (k)
            tbp_pkg::K_SIG: phase_next = tbp_pkg::K_SEQ;
            tbp_pkg::K_PK: begin
              if (e1 >= out_tot_next) begin
                elem_next = '0;
                phase_next = (has_wit_next && in_tot_next != '0) ?
                  tbp_pkg::K_WITCOUNT : tbp_pkg::K_LOCKTIME;
              end else begin
                elem_next = e1; phase_next = tbp_pkg::K_VALUE;
              end
            end
            default: begin
              wl1 = (wit_left != '0) ? wit_left - 1'b1 : wit_left;
              wit_left_next = wl1;
              if (wl1 == '0) begin
                elem_next = e1;
                phase_next = (e1 >= in_tot_next) ? tbp_pkg::K_LOCKTIME
                                                 : tbp_pkg::K_WITCOUNT;
              end else phase_next = tbp_pkg::K_WITLEN;
            end
          endcase
        end
      end else begin
        phase_next = k;
        if (vleft_next == '0) begin
          r.first = 1'b1; fbc_next = '0; vhi_next = 1'b0;
          if (data_byte < 8'hFD) begin
            vlo_next = {24'd0, data_byte}; done = 1'b1;
          end else begin
            vlo_next = '0;
            vleft_next = (data_byte == 8'hFD) ? 4'd2 :
                         (data_byte == 8'hFE) ? 4'd4 : 4'd8;
          end
        end else begin
          shifted = {24'd0, data_byte} << {fbc[1:0], 3'b000};
          if (fbc[2]) vhi_next = vhi | (data_byte != 8'h00);
          else vlo_next = vlo | shifted;
          fbc_next = fbc + 6'd1;
          vleft_next = vleft - 4'd1;
          done = (vleft_next == '0);
        end
        if (done) begin
          r.last = 1'b1; fbc_next = '0;
          is_count = (k == tbp_pkg::K_INCOUNT || k == tbp_pkg::K_OUTCOUNT ||
                      k == tbp_pkg::K_WITCOUNT);
          vz = (vlo_next == '0) && !vhi_next;
          over = vhi_next ||
            ({1'b0, vlo_next} > (is_count ? climit : llimit));
          if (over) begin
            r.err = is_count ? tbp_pkg::ERR_COUNT : tbp_pkg::ERR_LENGTH;
            phase_next = tbp_pkg::K_VERSION; vleft_next = '0;
          end else begin
            case (k)
              tbp_pkg::K_INCOUNT: begin
                in_tot_next = vlo_next[COUNT_WIDTH-1:0]; elem_next = '0;
                phase_next = vz ? tbp_pkg::K_OUTCOUNT : tbp_pkg::K_OUTPOINT;
              end
              tbp_pkg::K_OUTCOUNT: begin
                out_tot_next = vlo_next[COUNT_WIDTH-1:0]; elem_next = '0;
                if (vz) phase_next = (has_wit_next && in_tot_next != '0) ?
                  tbp_pkg::K_WITCOUNT : tbp_pkg::K_LOCKTIME;
                else phase_next = tbp_pkg::K_VALUE;
              end
              tbp_pkg::K_WITCOUNT: begin
                wit_left_next = vlo_next[COUNT_WIDTH-1:0];
                if (vz) begin
                  elem_next = e1;
                  phase_next = (e1 >= in_tot_next) ? tbp_pkg::K_LOCKTIME
                                                   : tbp_pkg::K_WITCOUNT;
                end else phase_next = tbp_pkg::K_WITLEN;
              end
              tbp_pkg::K_SIGLEN: begin
                rem_next = vlo_next[LENGTH_WIDTH-1:0];
                phase_next = vz ? tbp_pkg::K_SEQ : tbp_pkg::K_SIG;
              end
              tbp_pkg::K_PKLEN: begin
                rem_next = vlo_next[LENGTH_WIDTH-1:0];
                if (!vz) phase_next = tbp_pkg::K_PK;
                else if (e1 >= out_tot_next) begin
                  elem_next = '0;
                  phase_next = (has_wit_next && in_tot_next != '0) ?
                    tbp_pkg::K_WITCOUNT : tbp_pkg::K_LOCKTIME;
                end else begin
                  elem_next = e1; phase_next = tbp_pkg::K_VALUE;
                end
              end
              default: begin
                rem_next = vlo_next[LENGTH_WIDTH-1:0];
                if (!vz) phase_next = tbp_pkg::K_WITDATA;
                else begin
                  wl1 = (wit_left != '0) ? wit_left - 1'b1 : wit_left;
                  wit_left_next = wl1;
                  if (wl1 == '0) begin
                    elem_next = e1;
                    phase_next = (e1 >= in_tot_next) ? tbp_pkg::K_LOCKTIME
                                                     : tbp_pkg::K_WITCOUNT;
                  end else phase_next = tbp_pkg::K_WITLEN;
                end
              end
            endcase
          end
        end
      end
      if (held) res1 = r;
      else res0 = r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tbp_out_queue.sv =====
// ----------------------------------------------------------------------------
// tbp_out_queue
// Four-entry result queue. Up to two results enter per transfer; one leaves
// per output transfer. Input stall is raised when fewer than two slots are
// free.
// ----------------------------------------------------------------------------
`default_nettype none
module tbp_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [1:0]       push_count,
  input  wire tbp_pkg::result_t push0,
  input  wire tbp_pkg::result_t push1,
  output logic                  full,
  output logic                  valid,
  input  wire logic             stall,
  output tbp_pkg::result_t      head,
  output logic [2:0]            level
);
  tbp_pkg::result_t slots [4];
  logic [1:0] rd, wr;
  logic       pop;
  logic [1:0] n_in;

  assign pop   = valid && !stall;
  assign n_in  = push ? push_count : 2'd0;
  assign valid = (level != 3'd0);
  assign full  = (level > 3'd2);
  assign head  = slots[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; level <= '0;
    end else begin
      if (pop) rd <= rd + 2'd1;
      wr <= wr + n_in;
      level <= level + {1'b0, n_in} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) slots[wr] <= push0;
    if (n_in == 2'd2) slots[wr + 2'd1] <= push1;
  end
endmodule
`default_nettype wire

// ===== rtl/tx_byte_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tx_byte_stream_parser
// Tags each byte of a serialized transaction with its field.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low and classified in the
// same cycle into a small result queue, where results are registered. A zero
// byte in the input count position with marker recognition enabled yields
// nothing until the next byte, which then yields two results, so the output
// side sustains one result per cycle while out_stall is low, and the input
// stalls only while the queue holds more than two results.
`default_nettype none
`include "tx_byte_stream_parser_assert.svh"
module tx_byte_stream_parser #(
  parameter int unsigned COUNT_WIDTH  = tbp_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = tbp_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_value,
  output logic [4:0]       field_kind,
  output logic             field_first,
  output logic             field_last,
  output logic [15:0]      element_index,
  output logic             tx_last,
  output logic [1:0]       error_code
);
  logic [15:0] max_item_count;
  logic [19:0] max_script_length;
  logic        segwit_enable;
  logic        step, full;
  logic [1:0]  res_count;
  logic [2:0]  level;
  tbp_pkg::result_t res0, res1, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_item_count <= 16'd256; max_script_length <= 20'd10000;
      segwit_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tbp_pkg::REG_MAX_COUNT:  max_item_count <= cfg_data[15:0];
        tbp_pkg::REG_MAX_LENGTH: max_script_length <= cfg_data;
        tbp_pkg::REG_SEGWIT:     segwit_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign step     = in_valid && !full;

  tbp_core #(.COUNT_WIDTH(COUNT_WIDTH), .LENGTH_WIDTH(LENGTH_WIDTH)) u_core (
    .clk, .rst, .step, .data_byte, .max_item_count, .max_script_length,
    .segwit_enable, .res0, .res1, .res_count
  );

  tbp_out_queue u_queue (
    .clk, .rst, .push(step), .push_count(res_count), .push0(res0),
    .push1(res1), .full, .valid(out_valid), .stall(out_stall), .head, .level
  );

  assign byte_value    = head.byte_value;
  assign field_kind    = head.kind;
  assign field_first   = head.first;
  assign field_last    = head.last;
  assign element_index = head.index;
  assign tx_last       = head.tx_last;
  assign error_code    = head.err;

  `TBP_ASSERT_IMP(a_level_bound, clk, rst, 1'b1, level <= 3'd4)
  `TBP_ASSERT_IMP(a_txlast_locktime, clk, rst, out_valid && tx_last,
    field_kind == tbp_pkg::K_LOCKTIME && field_last)
  `TBP_ASSERT_IMP(a_err_on_last, clk, rst, out_valid && error_code != 2'd0,
    field_last)
endmodule
`default_nettype wire
